FILE: rtl/plwdm_pkg.sv
// ----------------------------------------------------------------------------
// plwdm_pkg
// shared types and constants for the positional list with delete-min
// ----------------------------------------------------------------------------
package plwdm_pkg;

    localparam int unsigned DEF_CAPACITY = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned LEN_W        = 8;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DELMIN = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [POS_W-1:0]         removed_position;
        logic signed [DATA_W-1:0] removed_value;
        logic [LEN_W-1:0]         length;
    } t_res;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] idx;
    } t_cell_cmd;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         idx;
    } t_cand;

endpackage

FILE: rtl/plwdm_cell.sv
// ----------------------------------------------------------------------------
// plwdm_cell
// one list slot: holds an entry, shifts with its neighbors, and carries a
// stage of the running-minimum chain
// ----------------------------------------------------------------------------
module plwdm_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                               i_clk,
    input  plwdm_pkg::t_cell_cmd               i_cmd,
    input  logic signed [plwdm_pkg::DATA_W-1:0] i_value,
    input  logic signed [plwdm_pkg::DATA_W-1:0] i_left_entry,
    input  logic signed [plwdm_pkg::DATA_W-1:0] i_right_entry,
    input  logic [plwdm_pkg::LEN_W-1:0]        i_count,
    input  plwdm_pkg::t_cand                   i_cand,
    output logic signed [plwdm_pkg::DATA_W-1:0] o_entry,
    output plwdm_pkg::t_cand                   o_cand
);

    localparam logic [plwdm_pkg::POS_W-1:0] MY_IDX = plwdm_pkg::POS_W'(INDEX);

    logic signed [plwdm_pkg::DATA_W-1:0] r_entry;
    logic signed [plwdm_pkg::DATA_W-1:0] n_entry;
    plwdm_pkg::t_cand                    r_cand;
    plwdm_pkg::t_cand                    n_cand;
    logic                                w_take_own;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && (MY_IDX > i_cmd.idx)) begin
            n_entry = i_left_entry;
        end else if (i_cmd.ins && (MY_IDX == i_cmd.idx)) begin
            n_entry = i_value;
        end else if (i_cmd.del && (MY_IDX >= i_cmd.idx)) begin
            n_entry = i_right_entry;
        end
    end

    // strict less keeps the lowest position among equal minima
    assign w_take_own = (INDEX == 0) ||
                        ((plwdm_pkg::LEN_W'(MY_IDX) < i_count) && (r_entry < i_cand.val));

    always_comb begin
        if (w_take_own) begin
            n_cand.val = r_entry;
            n_cand.idx = MY_IDX;
        end else begin
            n_cand = i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_cand  <= n_cand;
    end

    assign o_entry = r_entry;
    assign o_cand  = r_cand;

endmodule

FILE: rtl/positional_list_with_delete_min_core.sv
// ----------------------------------------------------------------------------
// positional_list_with_delete_min_core
// ordered list of signed words with insert, delete at position and delete-min
// ----------------------------------------------------------------------------
//  channel   ports                      transfer when
//  request   start, busy, i_req         start high and busy low at a clock edge
//  result    o_done, o_res              o_done high, held for one cycle only
//
//  insert and delete at position: an execute state, then the result register;
//  the list shift is done by all cells in parallel
//  delete-min on a non-empty list: an execute state, then a scan state until
//  the running-minimum chain, registered in every cell, reaches the last cell
//  reset clears the length and the control state; entries are never read
//  before they are written, so they carry no reset
//  the receiver cannot stall: a result is shown once and a new request is
//  taken in the same cycle
// ----------------------------------------------------------------------------
module positional_list_with_delete_min_core #(
    parameter int unsigned CAPACITY = plwdm_pkg::DEF_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  plwdm_pkg::t_req i_req,
    output logic            busy,
    output logic            o_done,
    output plwdm_pkg::t_res o_res
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = plwdm_pkg::POS_W + 1;
    localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 1);

    // control state
    plwdm_pkg::t_state r_state;
    plwdm_pkg::t_state n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [IW-1:0]     r_scan_cnt;
    logic [IW-1:0]     n_scan_cnt;
    logic              r_done;
    logic              n_done;

    // payload
    plwdm_pkg::t_req   r_req;
    plwdm_pkg::t_res   r_res;
    plwdm_pkg::t_res   n_res;

    // cell row
    plwdm_pkg::t_cell_cmd                w_cmd;
    logic signed [plwdm_pkg::DATA_W-1:0] w_entry [CAPACITY];
    plwdm_pkg::t_cand                    w_cand  [CAPACITY];
    logic [plwdm_pkg::LEN_W-1:0]         w_count_len;

    // request decode
    logic                           w_accept;
    logic [EW-1:0]                  w_pos_ext;
    logic [EW-1:0]                  w_cnt_ext;
    logic [plwdm_pkg::POS_W-1:0]    w_pos_m1;
    logic                           w_pos_nonzero;
    logic                           w_full;
    logic signed [plwdm_pkg::DATA_W-1:0] w_pos_entry;
    plwdm_pkg::t_cand               w_min;

    assign w_accept      = start && !busy;
    assign busy          = (r_state != plwdm_pkg::ST_IDLE);
    assign w_pos_ext     = EW'(r_req.position);
    assign w_cnt_ext     = EW'(r_count);
    assign w_pos_m1      = r_req.position - plwdm_pkg::POS_W'(1);
    assign w_pos_nonzero = (r_req.position != '0);
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_count_len   = plwdm_pkg::LEN_W'(r_count);
    assign w_pos_entry   = w_entry[w_pos_m1[IW-1:0]];
    assign w_min         = w_cand[CAPACITY-1];

    // row of cells; each shifts with its neighbors and forwards the minimum
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cells
            logic signed [plwdm_pkg::DATA_W-1:0] w_left;
            logic signed [plwdm_pkg::DATA_W-1:0] w_right;
            plwdm_pkg::t_cand                    w_cand_in;

            if (g == 0) begin : g_first
                assign w_left    = r_req.value;
                assign w_cand_in = '0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_cand_in = w_cand[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            plwdm_cell #(
                .INDEX(g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_value       (r_req.value),
                .i_left_entry  (w_left),
                .i_right_entry (w_right),
                .i_count       (w_count_len),
                .i_cand        (w_cand_in),
                .o_entry       (w_entry[g]),
                .o_cand        (w_cand[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plwdm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = plwdm_pkg::ST_EXEC;
                end
            end
            plwdm_pkg::ST_EXEC: begin
                if ((r_req.mode == plwdm_pkg::MODE_DELMIN) && (r_count != '0)) begin
                    n_state = plwdm_pkg::ST_SCAN;
                end else begin
                    n_state = plwdm_pkg::ST_IDLE;
                end
            end
            plwdm_pkg::ST_SCAN: begin
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = plwdm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plwdm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: cell commands, result and length
    always_comb begin
        w_cmd      = '0;
        n_count    = r_count;
        n_scan_cnt = '0;
        n_done     = 1'b0;
        n_res      = r_res;
        case (r_state)
            plwdm_pkg::ST_EXEC: begin
                n_res.status           = plwdm_pkg::STS_BADPOS;
                n_res.removed_position = '0;
                n_res.removed_value    = '0;
                n_done                 = 1'b1;
                case (r_req.mode)
                    plwdm_pkg::MODE_INSERT: begin
                        if (w_pos_nonzero && (w_pos_ext <= w_cnt_ext + EW'(1))) begin
                            if (w_full) begin
                                n_res.status = plwdm_pkg::STS_FULL;
                            end else begin
                                w_cmd.ins    = 1'b1;
                                w_cmd.idx    = w_pos_m1;
                                n_count      = r_count + CW'(1);
                                n_res.status = plwdm_pkg::STS_OK;
                            end
                        end
                    end
                    plwdm_pkg::MODE_DELETE: begin
                        if (w_pos_nonzero && (w_pos_ext <= w_cnt_ext)) begin
                            w_cmd.del              = 1'b1;
                            w_cmd.idx              = w_pos_m1;
                            n_count                = r_count - CW'(1);
                            n_res.status           = plwdm_pkg::STS_OK;
                            n_res.removed_position = r_req.position;
                            n_res.removed_value    = w_pos_entry;
                        end
                    end
                    plwdm_pkg::MODE_DELMIN: begin
                        if (r_count == '0) begin
                            n_res.status = plwdm_pkg::STS_EMPTY;
                        end else begin
                            // result comes at the end of the scan
                            n_done = 1'b0;
                        end
                    end
                    default: begin
                        n_res.status = plwdm_pkg::STS_BADPOS;
                    end
                endcase
                n_res.length = plwdm_pkg::LEN_W'(n_count);
            end
            plwdm_pkg::ST_SCAN: begin
                n_scan_cnt = r_scan_cnt + IW'(1);
                if (r_scan_cnt == SCAN_LAST) begin
                    // minimum has settled at the last cell
                    w_cmd.del              = 1'b1;
                    w_cmd.idx              = w_min.idx;
                    n_count                = r_count - CW'(1);
                    n_done                 = 1'b1;
                    n_res.status           = plwdm_pkg::STS_OK;
                    n_res.removed_position = w_min.idx + plwdm_pkg::POS_W'(1);
                    n_res.removed_value    = w_min.val;
                    n_res.length           = plwdm_pkg::LEN_W'(n_count);
                end
            end
            default: begin
                n_scan_cnt = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= plwdm_pkg::ST_IDLE;
            r_count    <= '0;
            r_scan_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_scan_cnt <= n_scan_cnt;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
